[src/grouped_fifo_queue_manager_assert.svh]
// Assertion macros shared by the queue manager modules.
`ifndef GROUPED_FIFO_QUEUE_MANAGER_ASSERT_SVH
`define GROUPED_FIFO_QUEUE_MANAGER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define GFQM_ASSERT_HOLD(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define GFQM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gfqm_pkg.sv]
`default_nettype none
package gfqm_pkg;

   // Fixed field widths and table sizes.
   localparam int ELEM_W        = 12;
   localparam int GROUP_W       = 8;
   localparam int ELEMENT_IDS   = 4096;
   localparam int MAX_GROUPS    = 256;
   localparam int NODE_CAPACITY = 1024;

   // Operation codes of a request.
   localparam logic [1:0] MODE_ASSIGN  = 2'd0;
   localparam logic [1:0] MODE_ENQUEUE = 2'd1;
   localparam logic [1:0] MODE_DEQUEUE = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   // Status codes of a response.
   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_DEQUEUED = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       init_step;
      logic       asn_write;
      logic       clear_q;
      logic       enq_look;
      logic       enq_link;
      logic       enq_fix;
      logic       deq_check;
      logic       deq_head;
      logic       deq_node;
      logic       deq_pop;
      logic       respond;
      logic [1:0] rsp_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic init_last;
      logic full;
      logic order_empty;
      logic link_needed;
   } stat_type;

endpackage
`default_nettype wire

[src/gfqm_ctrl.sv]
`default_nettype none
module gfqm_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [1:0]            req_mode,
   input  wire gfqm_pkg::stat_type stat,
   output logic                 busy,
   output gfqm_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_ASSIGN    = 4'd2;
   localparam logic [3:0] S_CLEAR     = 4'd3;
   localparam logic [3:0] S_ENQ_LOOK  = 4'd4;
   localparam logic [3:0] S_ENQ_LINK  = 4'd5;
   localparam logic [3:0] S_ENQ_FIX   = 4'd6;
   localparam logic [3:0] S_DEQ_CHECK = 4'd7;
   localparam logic [3:0] S_DEQ_HEAD  = 4'd8;
   localparam logic [3:0] S_DEQ_NODE  = 4'd9;
   localparam logic [3:0] S_DEQ_POP   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (req_mode)
                  gfqm_pkg::MODE_ASSIGN:  state_in = S_ASSIGN;
                  gfqm_pkg::MODE_ENQUEUE: state_in = S_ENQ_LOOK;
                  gfqm_pkg::MODE_DEQUEUE: state_in = S_DEQ_CHECK;
                  default:                state_in = S_CLEAR;
               endcase
            end
         end
         S_ASSIGN: begin
            cmd.asn_write = 1'b1;
            cmd.respond   = 1'b1;
            cmd.rsp_code  = gfqm_pkg::STAT_DONE;
            state_in      = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_q  = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_code = gfqm_pkg::STAT_DONE;
            state_in     = S_IDLE;
         end
         S_ENQ_LOOK: begin
            if (stat.full) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = gfqm_pkg::STAT_FULL;
               state_in     = S_IDLE;
            end else begin
               cmd.enq_look = 1'b1;
               state_in     = S_ENQ_LINK;
            end
         end
         S_ENQ_LINK: begin
            cmd.enq_link = 1'b1;
            if (stat.link_needed) begin
               state_in = S_ENQ_FIX;
            end else begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = gfqm_pkg::STAT_DONE;
               state_in     = S_IDLE;
            end
         end
         S_ENQ_FIX: begin
            cmd.enq_fix  = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_code = gfqm_pkg::STAT_DONE;
            state_in     = S_IDLE;
         end
         S_DEQ_CHECK: begin
            if (stat.order_empty) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = gfqm_pkg::STAT_EMPTY;
               state_in     = S_IDLE;
            end else begin
               cmd.deq_check = 1'b1;
               state_in      = S_DEQ_HEAD;
            end
         end
         S_DEQ_HEAD: begin
            cmd.deq_head = 1'b1;
            state_in     = S_DEQ_NODE;
         end
         S_DEQ_NODE: begin
            cmd.deq_node = 1'b1;
            state_in     = S_DEQ_POP;
         end
         S_DEQ_POP: begin
            cmd.deq_pop  = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_code = gfqm_pkg::STAT_DEQUEUED;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

`include "grouped_fifo_queue_manager_assert.svh"

   // An accepted transaction always leaves the idle state.
   `GFQM_ASSERT_NEXT(a_accept_busy, start && !busy, state_ff != S_IDLE, "accept not taken")
   // Every response ends the operation.
   `GFQM_ASSERT_NEXT(a_respond_idle, cmd.respond, state_ff == S_IDLE, "respond without idle")
   // The clearing sweep never overlaps a response.
   `GFQM_ASSERT_HOLD(a_init_quiet, !(cmd.init_step && cmd.respond), "respond during sweep")

endmodule
`default_nettype wire

[src/gfqm_datapath.sv]
`default_nettype none
module gfqm_datapath #(
   parameter int NODE_CAPACITY = gfqm_pkg::NODE_CAPACITY
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire [gfqm_pkg::ELEM_W-1:0]       req_element_id,
   input  wire [gfqm_pkg::GROUP_W-1:0]      req_group_id,
   input  wire gfqm_pkg::cmd_type           cmd,
   output gfqm_pkg::stat_type               stat,
   output logic                             rsp_strobe,
   output logic [gfqm_pkg::ELEM_W-1:0]      rsp_out_element,
   output logic [1:0]                       rsp_status
);

   localparam int EW = gfqm_pkg::ELEM_W;
   localparam int GW = gfqm_pkg::GROUP_W;
   localparam int NW = $clog2(NODE_CAPACITY);
   localparam int PW = NW + 1;
   localparam logic [PW-1:0] NULL_NODE = PW'(NODE_CAPACITY);
   localparam logic [GW:0]   ORDER_MAX = (GW+1)'(gfqm_pkg::MAX_GROUPS);

   // Memories.
   logic [GW-1:0] member_mem [gfqm_pkg::ELEMENT_IDS];
   logic [PW-1:0] head_mem   [gfqm_pkg::MAX_GROUPS];
   logic [NW-1:0] tail_mem   [gfqm_pkg::MAX_GROUPS];
   logic [GW-1:0] fifo_mem   [gfqm_pkg::MAX_GROUPS];
   logic [EW-1:0] nelem_mem  [NODE_CAPACITY];
   logic [PW-1:0] nnext_mem  [NODE_CAPACITY];

   logic [GW-1:0] member_rd;
   logic [PW-1:0] head_rd;
   logic [NW-1:0] tail_rd;
   logic [GW-1:0] fifo_rd;
   logic [EW-1:0] nelem_rd;
   logic [PW-1:0] nnext_rd;

   // Queue control state.
   logic [gfqm_pkg::MAX_GROUPS-1:0] present_ff;
   logic [GW-1:0] order_head_ff;
   logic [GW-1:0] order_tail_ff;
   logic [GW:0]   order_count_ff;
   logic [PW-1:0] free_head_ff;
   logic [PW-1:0] fresh_ff;
   logic [PW-1:0] used_ff;
   logic [EW-1:0] init_cnt_ff;

   // Per-transaction working registers.
   logic [EW-1:0] elem_ff;
   logic [GW-1:0] grp_ff;
   logic [GW-1:0] g_ff;
   logic [NW-1:0] n_ff;
   logic [NW-1:0] link_ff;

   logic          free_nonempty;
   logic [NW-1:0] new_node;

   assign free_nonempty = (free_head_ff < NULL_NODE);
   assign new_node      = free_nonempty ? free_head_ff[NW-1:0] : fresh_ff[NW-1:0];

   // Status toward the controller.
   always_comb begin
      stat.init_last   = &init_cnt_ff;
      stat.full        = (used_ff >= NULL_NODE);
      stat.order_empty = (order_count_ff == '0);
      stat.link_needed = present_ff[g_ff];
   end

   // Membership table: cleared by the sweep after reset, read on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         member_mem[init_cnt_ff] <= '0;
      end else if (cmd.asn_write) begin
         member_mem[elem_ff] <= grp_ff;
      end
      if (cmd.accept) begin
         member_rd <= member_mem[req_element_id];
      end
   end

   // Group head pointers.
   always_ff @(posedge clock) begin
      if (cmd.enq_link && !present_ff[g_ff]) begin
         head_mem[g_ff] <= PW'(new_node);
      end else if (cmd.deq_pop) begin
         head_mem[g_ff] <= nnext_rd;
      end
      if (cmd.deq_head) begin
         head_rd <= head_mem[fifo_rd];
      end
   end

   // Group tail pointers.
   always_ff @(posedge clock) begin
      if (cmd.enq_link) begin
         tail_mem[g_ff] <= new_node;
      end
      if (cmd.enq_look) begin
         tail_rd <= tail_mem[member_rd];
      end
   end

   // Group order FIFO.
   always_ff @(posedge clock) begin
      if (cmd.enq_link && !present_ff[g_ff]) begin
         fifo_mem[order_tail_ff] <= g_ff;
      end
      if (cmd.deq_check) begin
         fifo_rd <= fifo_mem[order_head_ff];
      end
   end

   // Node element store.
   always_ff @(posedge clock) begin
      if (cmd.enq_link) begin
         nelem_mem[new_node] <= elem_ff;
      end
      if (cmd.deq_node) begin
         nelem_rd <= nelem_mem[head_rd[NW-1:0]];
      end
   end

   // Node link store: one write and one read port, address chosen by the step.
   always_ff @(posedge clock) begin
      if (cmd.enq_link) begin
         nnext_mem[new_node] <= NULL_NODE;
      end else if (cmd.enq_fix) begin
         nnext_mem[link_ff] <= PW'(n_ff);
      end else if (cmd.deq_pop) begin
         nnext_mem[n_ff] <= free_head_ff;
      end
      if (cmd.enq_look) begin
         nnext_rd <= nnext_mem[free_nonempty ? free_head_ff[NW-1:0] : '0];
      end else if (cmd.deq_node) begin
         nnext_rd <= nnext_mem[head_rd[NW-1:0]];
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         elem_ff <= req_element_id;
         grp_ff  <= req_group_id;
      end
      if (cmd.enq_look) begin
         g_ff <= member_rd;
      end else if (cmd.deq_head) begin
         g_ff <= fifo_rd;
      end
      if (cmd.enq_link) begin
         n_ff    <= new_node;
         link_ff <= tail_rd;
      end else if (cmd.deq_node) begin
         n_ff <= head_rd[NW-1:0];
      end
   end

   // Queue bookkeeping and the reset sweep counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_q) begin
         present_ff     <= '0;
         order_head_ff  <= '0;
         order_tail_ff  <= '0;
         order_count_ff <= '0;
         free_head_ff   <= NULL_NODE;
         fresh_ff       <= '0;
         used_ff        <= '0;
      end else if (cmd.enq_link) begin
         used_ff <= used_ff + 1'b1;
         if (free_nonempty) begin
            free_head_ff <= nnext_rd;
         end else begin
            fresh_ff <= fresh_ff + 1'b1;
         end
         if (!present_ff[g_ff]) begin
            present_ff[g_ff] <= 1'b1;
            order_tail_ff    <= order_tail_ff + 1'b1;
            order_count_ff   <= order_count_ff + 1'b1;
         end
      end else if (cmd.deq_pop) begin
         used_ff      <= used_ff - 1'b1;
         free_head_ff <= PW'(n_ff);
         if (nnext_rd >= NULL_NODE) begin
            present_ff[g_ff] <= 1'b0;
            order_head_ff    <= order_head_ff + 1'b1;
            order_count_ff   <= order_count_ff - 1'b1;
         end
      end
      if (reset) begin
         init_cnt_ff <= '0;
      end else if (cmd.init_step) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   // Response register: one strobe cycle per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.respond;
      end
      rsp_status      <= cmd.rsp_code;
      rsp_out_element <= cmd.deq_pop ? nelem_rd : '0;
   end

`include "grouped_fifo_queue_manager_assert.svh"

   // Node use never exceeds the store.
   `GFQM_ASSERT_HOLD(a_used_bound, used_ff <= NULL_NODE, "node count overflow")
   // The group order FIFO never holds more groups than exist.
   `GFQM_ASSERT_HOLD(a_order_bound, order_count_ff <= ORDER_MAX, "order overflow")
   // A dequeue never pops a node while the store is empty.
   `GFQM_ASSERT_HOLD(a_pop_used, !cmd.deq_pop || (used_ff != '0), "pop from empty store")

endmodule
`default_nettype wire

[src/grouped_fifo_queue_manager.sv]
`default_nettype none
// Channel   Ports                                          Handshake
// request   req_mode, req_element_id, req_group_id         start high, busy low
// response  rsp_out_element, rsp_status                    rsp_strobe, one cycle
//
// Assign and clear respond from one state, enqueue from its look (full), link
// or fix state (when the node must be linked behind the group tail), dequeue
// from its check state (empty) or after walking order FIFO, head pointer and
// node store one memory read per cycle. busy falls in the strobe cycle, so the
// next transaction may start then. After reset the membership table is zeroed,
// one entry a cycle, with busy high. The receiver cannot stall the response.
module grouped_fifo_queue_manager #(
   parameter int NODE_CAPACITY = gfqm_pkg::NODE_CAPACITY
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [1:0]                        req_mode,
   input  wire [gfqm_pkg::ELEM_W-1:0]       req_element_id,
   input  wire [gfqm_pkg::GROUP_W-1:0]      req_group_id,
   output logic                             rsp_strobe,
   output logic [gfqm_pkg::ELEM_W-1:0]      rsp_out_element,
   output logic [1:0]                       rsp_status
);

   gfqm_pkg::cmd_type  cmd;
   gfqm_pkg::stat_type stat;

   // Sequencer for each operation.
   gfqm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Memories, pointers and response register.
   gfqm_datapath #(
      .NODE_CAPACITY (NODE_CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_element_id  (req_element_id),
      .req_group_id    (req_group_id),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_element (rsp_out_element),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire
